FILE: hw/rtl/least_connections_flow_balancer_core_defines.svh
// ----------------------------------------------------------------------------
// Flow balancer assertion macros
// Shared property macros for the checker of the flow balancer core.
// ----------------------------------------------------------------------------
`ifndef LEAST_CONNECTIONS_FLOW_BALANCER_CORE_DEFINES_SVH
`define LEAST_CONNECTIONS_FLOW_BALANCER_CORE_DEFINES_SVH

// Same-cycle implication.
`define LCFB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lcfb assertion failed");

// Next-cycle implication.
`define LCFB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lcfb assertion failed");

`endif

FILE: hw/rtl/lcfb_pkg.sv
// ----------------------------------------------------------------------------
// Flow balancer package
// Types and constants shared by the flow balancer modules.
// ----------------------------------------------------------------------------
package lcfb_pkg;

  localparam int unsigned SLOT_W = 3;
  localparam int unsigned LOAD_W = 7;
  localparam logic [LOAD_W-1:0] LOAD_MAX = 7'd127;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  typedef enum logic [2:0] {
    MODE_PACKET       = 3'd0,
    MODE_FLOW_REMOVED = 3'd1,
    MODE_PORT_UP      = 3'd2,
    MODE_PORT_DOWN    = 3'd3,
    MODE_WRITE_SLOT   = 3'd4
  } mode_e;

  typedef enum logic [4:0] {
    RES_OTHER_SWITCH     = 5'd0,
    RES_NOT_IPV4_TCP     = 5'd1,
    RES_NO_BACKEND       = 5'd2,
    RES_BOTH_BACKENDS    = 5'd3,
    RES_REVERSE          = 5'd4,
    RES_REVERSE_UNKNOWN  = 5'd5,
    RES_ALREADY_BALANCED = 5'd6,
    RES_ASSIGNED         = 5'd7,
    RES_NONE_UP          = 5'd8,
    RES_TABLE_FULL       = 5'd9,
    RES_REMOVED          = 5'd10,
    RES_UNKNOWN_COOKIE   = 5'd11,
    RES_PORT_UP          = 5'd12,
    RES_PORT_UNMATCHED   = 5'd13,
    RES_DELETE_COOKIE    = 5'd14,
    RES_NO_FLOWS         = 5'd15,
    RES_WRITTEN          = 5'd16
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_TAIL,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [30:0] switch_id;
    logic [15:0] l2_type;
    logic [7:0]  l4_proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [63:0] cookie;
    logic [31:0] port;
    logic [2:0]  slot;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  chosen_slot;
    logic [31:0] chosen_ip;
    logic [47:0] chosen_mac;
    logic [31:0] chosen_port;
    logic [63:0] delete_cookie;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [47:0]       cli_mac;
    logic [47:0]       srv_mac;
    logic [63:0]       cookie;
    logic [SLOT_W-1:0] owner;
  } flow_entry_t;

  typedef struct packed {
    status_e           status;
    logic              has_backend;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       del_cookie;
    logic              last;
  } req_t;

endpackage

FILE: hw/rtl/lcfb_flow_mem.sv
// ----------------------------------------------------------------------------
// Flow table memory
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module lcfb_flow_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  lcfb_pkg::flow_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output lcfb_pkg::flow_entry_t rdata_o
);
  import lcfb_pkg::*;

  flow_entry_t mem_q [DEPTH];
  flow_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/least_connections_flow_balancer_core.sv
// ----------------------------------------------------------------------------
// Least-connections flow balancer core
// Backend table in registers, flow table in a synchronous memory that is
// scanned one entry per cycle for lookups, inserts, removals and deletes.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  config    cfg_we_i             cfg_wdata_i (switch id)
//  command   start / busy         item_i
//  result    res_valid_o          result_o
//
// Events that touch only the backend table are decided in the decode state, and
// their result passes through the request and output registers. Packet events
// that reach the flow table, flow removal and port down scan the flow memory,
// one read per cycle. Port down delivers one word per owned flow, the last one
// after the scan ends. Reset clears all valid bits at once, so no clearing pass
// is needed. Results cannot be stalled.
module least_connections_flow_balancer_core #(
  parameter int unsigned MAX_BACKENDS = 8,
  parameter int unsigned MAX_FLOWS    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i,
  input  logic              start,
  input  lcfb_pkg::item_t   item_i,
  output logic              busy,
  output logic              res_valid_o,
  output lcfb_pkg::result_t result_o
);
  import lcfb_pkg::*;

  localparam int unsigned NB = (MAX_BACKENDS < (2 ** SLOT_W)) ? MAX_BACKENDS : (2 ** SLOT_W);
  localparam int unsigned BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned FW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int unsigned SCAN_LEN = (MAX_FLOWS > NB) ? MAX_FLOWS : ((NB > 1) ? NB : 2);
  localparam int unsigned SW = $clog2(SCAN_LEN);

  fsm_e state_q, state_d;
  logic [30:0] sw_id_q;
  item_t in_q;

  logic [NB-1:0] bvalid_q, bup_q;
  logic [31:0] bip_q [NB];
  logic [47:0] bmac_q [NB];
  logic [31:0] bport_q [NB];
  logic [LOAD_W-1:0] bload_q [NB];

  logic [MAX_FLOWS-1:0] fvalid_q;

  logic [SW-1:0] sc_q;
  logic rvalid_q;
  logic [FW-1:0] ridx_q;
  logic best_found_q, free_found_q, pend_q;
  logic [BW-1:0] best_idx_q, bsel_q;
  logic [LOAD_W-1:0] best_load_q;
  logic [FW-1:0] free_idx_q;
  logic [63:0] pend_cookie_q;

  logic req_valid_q, req_valid_d;
  req_t req_q, req_d;
  logic out_valid_q;
  result_t out_q;

  flow_entry_t rdata, wdata;
  logic rd_en, mem_we;

  logic sip_hit, dip_hit, smac_hit, port_hit;
  logic [BW-1:0] smac_idx, port_idx;
  logic sw_ok, pkt_ok, slot_ok;
  logic exam, ent_valid, pair_hit, cookie_hit, own_hit;
  logic is_pkt, is_rem, is_down;
  logic [BW-1:0] scan_bidx, owner_idx;
  logic min_take;

  logic bk_write, up_set, up_clr, load_inc, load_dec, fv_set, fv_clr, bsel_load, scan_init;

  always_comb begin
    sip_hit  = 1'b0;
    dip_hit  = 1'b0;
    smac_hit = 1'b0;
    port_hit = 1'b0;
    smac_idx = '0;
    port_idx = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (bvalid_q[i] && bip_q[i] == in_q.src_ip) begin
        sip_hit = 1'b1;
      end
      if (bvalid_q[i] && bip_q[i] == in_q.dst_ip) begin
        dip_hit = 1'b1;
      end
      if (bvalid_q[i] && bmac_q[i] == in_q.src_mac) begin
        smac_hit = 1'b1;
        smac_idx = BW'(i);
      end
      if (bvalid_q[i] && bport_q[i] == in_q.port) begin
        port_hit = 1'b1;
        port_idx = BW'(i);
      end
    end
  end

  assign sw_ok   = (in_q.switch_id == sw_id_q);
  assign pkt_ok  = (in_q.l2_type == ETH_IPV4) && (in_q.l4_proto == PROTO_TCP);
  assign slot_ok = (32'(in_q.slot) < NB);
  assign is_pkt  = (in_q.mode == MODE_PACKET);
  assign is_rem  = (in_q.mode == MODE_FLOW_REMOVED);
  assign is_down = (in_q.mode == MODE_PORT_DOWN);

  assign exam       = rvalid_q && ((state_q == S_SCAN) || (state_q == S_TAIL));
  assign ent_valid  = fvalid_q[ridx_q];
  assign pair_hit   = exam && ent_valid && is_pkt && (rdata.cli_mac == in_q.src_mac) &&
                      (rdata.srv_mac == in_q.dst_mac);
  assign cookie_hit = exam && ent_valid && is_rem && (rdata.cookie == in_q.cookie);
  assign own_hit    = exam && ent_valid && is_down && (rdata.owner == SLOT_W'(bsel_q));
  assign owner_idx  = rdata.owner[BW-1:0];

  assign rd_en     = (state_q == S_SCAN) && (32'(sc_q) < MAX_FLOWS);
  assign scan_bidx = sc_q[BW-1:0];
  assign min_take  = (state_q == S_SCAN) && (32'(sc_q) < NB) && bvalid_q[scan_bidx] &&
                     bup_q[scan_bidx] && (!best_found_q || bload_q[scan_bidx] < best_load_q);

  assign wdata.cli_mac = in_q.src_mac;
  assign wdata.srv_mac = in_q.dst_mac;
  assign wdata.cookie  = in_q.cookie;
  assign wdata.owner   = SLOT_W'(best_idx_q);

  lcfb_flow_mem #(
    .DEPTH(MAX_FLOWS),
    .AW   (FW)
  ) u_flow_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(free_idx_q),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(sc_q[FW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start && !busy) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (in_q.mode)
          MODE_PACKET: begin
            if (sw_ok && pkt_ok && !sip_hit && dip_hit) begin
              state_d = S_SCAN;
            end else begin
              state_d = S_IDLE;
            end
          end
          MODE_FLOW_REMOVED: state_d = S_SCAN;
          MODE_PORT_DOWN:    state_d = port_hit ? S_SCAN : S_IDLE;
          default:           state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (pair_hit || cookie_hit) begin
          state_d = S_IDLE;
        end else if (sc_q == SW'(SCAN_LEN - 1)) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: state_d = (pair_hit || cookie_hit) ? S_IDLE : S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_valid_d = 1'b0;
    req_d       = '{status: RES_OTHER_SWITCH, has_backend: 1'b0, slot: '0,
                    del_cookie: '0, last: 1'b1};
    bk_write  = 1'b0;
    up_set    = 1'b0;
    up_clr    = 1'b0;
    load_inc  = 1'b0;
    load_dec  = 1'b0;
    fv_set    = 1'b0;
    fv_clr    = 1'b0;
    mem_we    = 1'b0;
    bsel_load = 1'b0;
    scan_init = 1'b0;
    case (state_q)
      S_DECODE: begin
        scan_init = 1'b1;
        case (in_q.mode)
          MODE_PACKET: begin
            if (!sw_ok) begin
              req_valid_d  = 1'b1;
              req_d.status = RES_OTHER_SWITCH;
            end else if (!pkt_ok) begin
              req_valid_d  = 1'b1;
              req_d.status = RES_NOT_IPV4_TCP;
            end else if (!sip_hit && !dip_hit) begin
              req_valid_d  = 1'b1;
              req_d.status = RES_NO_BACKEND;
            end else if (sip_hit && dip_hit) begin
              req_valid_d  = 1'b1;
              req_d.status = RES_BOTH_BACKENDS;
            end else if (sip_hit) begin
              req_valid_d       = 1'b1;
              req_d.status      = smac_hit ? RES_REVERSE : RES_REVERSE_UNKNOWN;
              req_d.has_backend = smac_hit;
              req_d.slot        = SLOT_W'(smac_idx);
            end
          end
          MODE_PORT_UP: begin
            req_valid_d       = 1'b1;
            req_d.status      = port_hit ? RES_PORT_UP : RES_PORT_UNMATCHED;
            req_d.has_backend = port_hit;
            req_d.slot        = SLOT_W'(port_idx);
            up_set            = port_hit;
          end
          MODE_PORT_DOWN: begin
            if (port_hit) begin
              up_clr    = 1'b1;
              bsel_load = 1'b1;
            end else begin
              req_valid_d  = 1'b1;
              req_d.status = RES_PORT_UNMATCHED;
            end
          end
          MODE_WRITE_SLOT: begin
            req_valid_d       = 1'b1;
            req_d.status      = RES_WRITTEN;
            req_d.has_backend = slot_ok;
            req_d.slot        = in_q.slot;
            bk_write          = slot_ok;
          end
          default: ;
        endcase
      end
      S_SCAN, S_TAIL: begin
        if (pair_hit) begin
          req_valid_d       = 1'b1;
          req_d.status      = RES_ALREADY_BALANCED;
          req_d.has_backend = (32'(rdata.owner) < NB);
          req_d.slot        = rdata.owner;
        end else if (cookie_hit) begin
          req_valid_d       = 1'b1;
          req_d.status      = RES_REMOVED;
          req_d.has_backend = (32'(rdata.owner) < NB);
          req_d.slot        = rdata.owner;
          fv_clr            = 1'b1;
          load_dec          = (32'(rdata.owner) < NB);
        end else if (own_hit && pend_q) begin
          req_valid_d       = 1'b1;
          req_d.status      = RES_DELETE_COOKIE;
          req_d.has_backend = 1'b1;
          req_d.slot        = SLOT_W'(bsel_q);
          req_d.del_cookie  = pend_cookie_q;
          req_d.last        = 1'b0;
        end
      end
      S_FINISH: begin
        req_valid_d = 1'b1;
        if (is_pkt) begin
          if (!best_found_q) begin
            req_d.status = RES_NONE_UP;
          end else if (!free_found_q) begin
            req_d.status = RES_TABLE_FULL;
          end else begin
            req_d.status      = RES_ASSIGNED;
            req_d.has_backend = 1'b1;
            req_d.slot        = SLOT_W'(best_idx_q);
            mem_we            = 1'b1;
            fv_set            = 1'b1;
            load_inc          = 1'b1;
          end
        end else if (is_rem) begin
          req_d.status = RES_UNKNOWN_COOKIE;
        end else begin
          req_d.status      = pend_q ? RES_DELETE_COOKIE : RES_NO_FLOWS;
          req_d.has_backend = 1'b1;
          req_d.slot        = SLOT_W'(bsel_q);
          req_d.del_cookie  = pend_q ? pend_cookie_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sw_id_q      <= 31'd1;
      bvalid_q     <= '0;
      bup_q        <= '0;
      fvalid_q     <= '0;
      rvalid_q     <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      pend_q       <= 1'b0;
      req_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        bload_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rvalid_q    <= rd_en;
      req_valid_q <= req_valid_d;
      out_valid_q <= req_valid_q;
      if (cfg_we_i) begin
        sw_id_q <= cfg_wdata_i;
      end
      if (bk_write) begin
        bvalid_q[in_q.slot[BW-1:0]] <= 1'b1;
        bup_q[in_q.slot[BW-1:0]]    <= 1'b1;
      end
      if (up_set) begin
        bup_q[port_idx] <= 1'b1;
      end
      if (up_clr) begin
        bup_q[port_idx] <= 1'b0;
      end
      if (load_inc && bload_q[best_idx_q] != LOAD_MAX) begin
        bload_q[best_idx_q] <= bload_q[best_idx_q] + 1'b1;
      end
      if (load_dec && bload_q[owner_idx] != '0) begin
        bload_q[owner_idx] <= bload_q[owner_idx] - 1'b1;
      end
      if (fv_set) begin
        fvalid_q[free_idx_q] <= 1'b1;
      end
      if (fv_clr) begin
        fvalid_q[ridx_q] <= 1'b0;
      end
      if (scan_init) begin
        best_found_q <= 1'b0;
        free_found_q <= 1'b0;
        pend_q       <= 1'b0;
      end else begin
        if (min_take) begin
          best_found_q <= 1'b1;
        end
        if (exam && !ent_valid) begin
          free_found_q <= 1'b1;
        end
        if (own_hit) begin
          pend_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start && !busy) begin
      in_q <= item_i;
    end
    if (bk_write) begin
      bip_q[in_q.slot[BW-1:0]]   <= in_q.src_ip;
      bmac_q[in_q.slot[BW-1:0]]  <= in_q.src_mac;
      bport_q[in_q.slot[BW-1:0]] <= in_q.port;
    end
    if (bsel_load) begin
      bsel_q <= port_idx;
    end
    if (scan_init) begin
      sc_q <= '0;
    end else if (state_q == S_SCAN && sc_q != SW'(SCAN_LEN - 1)) begin
      sc_q <= sc_q + 1'b1;
    end
    ridx_q <= sc_q[FW-1:0];
    if (min_take) begin
      best_idx_q  <= scan_bidx;
      best_load_q <= bload_q[scan_bidx];
    end
    if (exam && !ent_valid && !free_found_q) begin
      free_idx_q <= ridx_q;
    end
    if (own_hit) begin
      pend_cookie_q <= rdata.cookie;
    end
    req_q <= req_d;
    out_q.status        <= req_q.status;
    out_q.delete_cookie <= req_q.del_cookie;
    out_q.last          <= req_q.last;
    if (req_q.has_backend) begin
      out_q.chosen_slot <= req_q.slot;
      out_q.chosen_ip   <= bip_q[req_q.slot[BW-1:0]];
      out_q.chosen_mac  <= bmac_q[req_q.slot[BW-1:0]];
      out_q.chosen_port <= bport_q[req_q.slot[BW-1:0]];
    end else begin
      out_q.chosen_slot <= '0;
      out_q.chosen_ip   <= '0;
      out_q.chosen_mac  <= '0;
      out_q.chosen_port <= '0;
    end
  end

  assign busy        = (state_q != S_IDLE) || req_valid_q;
  assign res_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

FILE: hw/rtl/lcfb_checker.sv
// ----------------------------------------------------------------------------
// Flow balancer port checker
// Port-level properties of the flow balancer core, bound to the core module.
// ----------------------------------------------------------------------------
`include "least_connections_flow_balancer_core_defines.svh"

module lcfb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input lcfb_pkg::result_t result_o
);
  import lcfb_pkg::*;

  `LCFB_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `LCFB_ASSERT_IMP(a_word_after_busy, clk_i, rst_ni, res_valid_o, $past(busy))
  `LCFB_ASSERT_IMP(a_more_keeps_busy, clk_i, rst_ni, res_valid_o && !result_o.last, busy)
  `LCFB_ASSERT_IMP(a_more_is_delete, clk_i, rst_ni, res_valid_o && !result_o.last,
                   result_o.status == RES_DELETE_COOKIE)

endmodule

bind least_connections_flow_balancer_core lcfb_checker u_lcfb_checker (.*);
